// ===== sv/evdl_pkg.sv =====
`default_nettype none
package evdl_pkg;

	// Field and register widths
	localparam int COUNT_W         = 27;
	localparam int SPEED_W         = 24;
	localparam int DUTY_W          = 8;
	localparam int DIR_W           = 2;
	localparam int GAIN_W          = 16;
	localparam int CPT_W           = 16;
	localparam int PER_W           = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 24;

	// Arithmetic constants
	localparam int COUNT_MODULUS   = 100000000;
	localparam int SPEED_FRAC_BITS = 8;
	localparam int SKIP_LIMIT      = 10000;
	localparam int MS_SCALE        = 1000;
	localparam int TWOPI_Q20       = 6588397;
	localparam int ERR_SCALE       = 5;
	localparam int DUTY_MIN        = 20;
	localparam int DUTY_MAX        = 255;
	localparam int SPEED_MAX       = 8388607;
	localparam int DUTY_SHIFT      = SPEED_FRAC_BITS + 8;
	localparam int NUM_SHIFT       = 20 - SPEED_FRAC_BITS;

	// Datapath widths
	localparam int DIFF_W          = COUNT_W + 1;
	localparam int MAG_W           = 14;
	localparam int PROD1_W         = MAG_W + 10;
	localparam int ACC_W           = PROD1_W + 23;
	localparam int NUM_W           = ACC_W - NUM_SHIFT;
	localparam int DEN_W           = CPT_W + PER_W;
	localparam int DIV_CNT_W       = $clog2(NUM_W);
	localparam int ERR_W           = 26;
	localparam int PROD_W          = ERR_W + GAIN_W;
	localparam int STEP_W          = 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CPT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 3'd4;

	// Item kinds and drive codes
	localparam logic OPC_SAMPLE = 1'b0;
	localparam logic OPC_TICK   = 1'b1;

	localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
	localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

	// Payloads
	typedef struct packed {
		logic opcode;
		logic chan_a_level;
		logic chan_b_level;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]        position_count;
		logic signed [SPEED_W-1:0] speed_q8;
		logic [DUTY_W-1:0]         duty;
		logic                      duty_written;
		logic [DIR_W-1:0]          drive_dir;
	} result_t;

	// Microcode
	typedef enum logic [3:0] {
		OP_NOP,
		OP_SAMPLE,
		OP_DIFF,
		OP_MUL1,
		OP_MUL2,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_SPEED,
		OP_ERR,
		OP_PMUL,
		OP_DUTY,
		OP_OUT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_TICK,
		COND_SKIP,
		COND_DIV_MORE
	} cond_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
		logic              last;
	} ucode_word_t;

	typedef struct packed {
		logic is_tick;
		logic skip;
		logic div_more;
		logic out_block;
	} seq_status_t;

	// Program addresses
	localparam logic [STEP_W-1:0] ST_DISPATCH = 4'd0;
	localparam logic [STEP_W-1:0] ST_SAMPLE   = 4'd1;
	localparam logic [STEP_W-1:0] ST_DIFF     = 4'd2;
	localparam logic [STEP_W-1:0] ST_MUL1     = 4'd3;
	localparam logic [STEP_W-1:0] ST_MUL2     = 4'd4;
	localparam logic [STEP_W-1:0] ST_DIV_INIT = 4'd5;
	localparam logic [STEP_W-1:0] ST_DIV_STEP = 4'd6;
	localparam logic [STEP_W-1:0] ST_SPEED    = 4'd7;
	localparam logic [STEP_W-1:0] ST_ERR      = 4'd8;
	localparam logic [STEP_W-1:0] ST_PMUL     = 4'd9;
	localparam logic [STEP_W-1:0] ST_DUTY     = 4'd10;
	localparam logic [STEP_W-1:0] ST_OUT      = 4'd11;

	// Control store
	function automatic ucode_word_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_word_t w;
		w = '{op: OP_NOP, cond: COND_NEXT, target: ST_DISPATCH, last: 1'b1};
		unique case (step)
			ST_DISPATCH: w = '{OP_NOP,      COND_TICK,     ST_DIFF,     1'b0};
			ST_SAMPLE:   w = '{OP_SAMPLE,   COND_ALWAYS,   ST_OUT,      1'b0};
			ST_DIFF:     w = '{OP_DIFF,     COND_NEXT,     ST_DISPATCH, 1'b0};
			ST_MUL1:     w = '{OP_MUL1,     COND_SKIP,     ST_ERR,      1'b0};
			ST_MUL2:     w = '{OP_MUL2,     COND_NEXT,     ST_DISPATCH, 1'b0};
			ST_DIV_INIT: w = '{OP_DIV_INIT, COND_NEXT,     ST_DISPATCH, 1'b0};
			ST_DIV_STEP: w = '{OP_DIV_STEP, COND_DIV_MORE, ST_DIV_STEP, 1'b0};
			ST_SPEED:    w = '{OP_SPEED,    COND_NEXT,     ST_DISPATCH, 1'b0};
			ST_ERR:      w = '{OP_ERR,      COND_NEXT,     ST_DISPATCH, 1'b0};
			ST_PMUL:     w = '{OP_PMUL,     COND_NEXT,     ST_DISPATCH, 1'b0};
			ST_DUTY:     w = '{OP_DUTY,     COND_NEXT,     ST_DISPATCH, 1'b0};
			ST_OUT:      w = '{OP_OUT,      COND_NEXT,     ST_DISPATCH, 1'b1};
			default:     w = '{OP_NOP,      COND_NEXT,     ST_DISPATCH, 1'b1};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== sv/evdl_seq.sv =====
`default_nettype none
module evdl_seq
	import evdl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire seq_status_t status,
	output op_t              op,
	output logic             busy
);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	ucode_word_t       cw;
	logic              stall;
	logic              take;

	// Fetch and branch decision
	always_comb begin
		cw    = ucode_rom(step_q);
		stall = (cw.op == OP_OUT) && status.out_block;
		unique case (cw.cond)
			COND_NEXT:     take = 1'b0;
			COND_ALWAYS:   take = 1'b1;
			COND_TICK:     take = status.is_tick;
			COND_SKIP:     take = status.skip;
			COND_DIV_MORE: take = status.div_more;
			default:       take = 1'b0;
		endcase
	end

	assign op   = (busy_q && !stall) ? cw.op : OP_NOP;
	assign busy = busy_q;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_DISPATCH;
		end else if (!busy_q) begin
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= ST_DISPATCH;
			end
		end else if (!stall) begin
			if (cw.last) begin
				busy_q <= 1'b0;
			end else if (take) begin
				step_q <= cw.target;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/evdl_dp.sv =====
`default_nettype none
module evdl_dp
	import evdl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire item_t                 item,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire op_t                   op,
	output seq_status_t                status,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output result_t                    result
);

	// Configuration
	logic signed [SPEED_W-1:0] target_q;
	logic [GAIN_W-1:0]         gain_q;
	logic [CPT_W-1:0]          cpt_q;
	logic [PER_W-1:0]          period_q;
	logic [DUTY_W-1:0]         ceiling_q;

	// Request and controller state
	item_t                     item_q;
	logic                      last_a_q;
	logic                      dir_bit_q;
	logic [COUNT_W-1:0]        count_q;
	logic [COUNT_W-1:0]        prev_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic [DUTY_W-1:0]         duty_reg_q;
	logic [DIR_W-1:0]          dir_q;

	// Working registers
	logic signed [DIFF_W-1:0]  diff_q;
	logic [DEN_W-1:0]          den_q;
	logic [ACC_W-1:0]          acc_q;
	logic [NUM_W-1:0]          num_q;
	logic [DEN_W-1:0]          rem_q;
	logic [DIV_CNT_W-1:0]      div_cnt_q;
	logic [ERR_W-1:0]          err_mag_q;
	logic                      err_neg_q;
	logic [PROD_W-1:0]         prod_q;
	logic [DUTY_W-1:0]         duty_out_q;
	logic                      written_q;
	logic                      res_valid_q;
	result_t                   res_q;

	// Combinational helpers
	logic                      dir_new;
	logic [DIFF_W-1:0]         diff_mag;
	logic [CPT_W-1:0]          cpt_eff;
	logic [PER_W-1:0]          per_eff;
	logic [DEN_W:0]            trial;
	logic                      trial_ok;
	logic [SPEED_W-1:0]        speed_sat;
	logic [SPEED_W:0]          t_ext, s_ext, t_mag, s_mag;
	logic [SPEED_W+1:0]        e_diff, e_abs;
	logic signed [ERR_W+1:0]   duty_sum;
	logic [ERR_W+1:0]          duty_ext, dmag_ext;
	logic [DUTY_W-1:0]         duty_new;
	logic                      load_out;

	// Sample: edge on A latches B as direction
	assign dir_new = (!last_a_q && item_q.chan_a_level) ? item_q.chan_b_level : dir_bit_q;

	// Tick: count difference and divisor
	assign diff_mag = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
	assign cpt_eff  = (cpt_q == '0) ? CPT_W'(1) : cpt_q;
	assign per_eff  = (period_q == '0) ? PER_W'(1) : period_q;

	// Restoring divider, one quotient bit per step
	assign trial    = {rem_q, num_q[NUM_W-1]};
	assign trial_ok = trial >= {1'b0, den_q};

	// Speed saturation on the quotient
	always_comb begin
		if (diff_q[DIFF_W-1]) begin
			if (num_q > NUM_W'(SPEED_MAX + 1))
				speed_sat = SPEED_W'(SPEED_MAX + 1);
			else
				speed_sat = SPEED_W'(-num_q);
		end else begin
			if (num_q > NUM_W'(SPEED_MAX))
				speed_sat = SPEED_W'(SPEED_MAX);
			else
				speed_sat = num_q[SPEED_W-1:0];
		end
	end

	// Error magnitude |target| - |speed|
	always_comb begin
		t_ext  = {target_q[SPEED_W-1], target_q};
		s_ext  = {speed_q[SPEED_W-1], speed_q};
		t_mag  = t_ext[SPEED_W] ? -t_ext : t_ext;
		s_mag  = s_ext[SPEED_W] ? -s_ext : s_ext;
		e_diff = {1'b0, t_mag} - {1'b0, s_mag};
		e_abs  = e_diff[SPEED_W+1] ? -e_diff : e_diff;
	end

	// Duty update and clamp
	always_comb begin
		duty_ext = (ERR_W+2)'(duty_reg_q);
		dmag_ext = (ERR_W+2)'(prod_q[PROD_W-1:DUTY_SHIFT]);
		duty_sum = err_neg_q ? $signed(duty_ext - dmag_ext) : $signed(duty_ext + dmag_ext);
		if (duty_sum < $signed((ERR_W+2)'(DUTY_MIN)))
			duty_new = DUTY_W'(DUTY_MIN);
		else if (duty_sum > $signed((ERR_W+2)'(DUTY_MAX)))
			duty_new = DUTY_W'(DUTY_MAX);
		else
			duty_new = duty_sum[DUTY_W-1:0];
	end

	assign load_out = (op == OP_OUT);

	assign status.is_tick   = (item_q.opcode == OPC_TICK);
	assign status.skip      = diff_mag >= DIFF_W'(SKIP_LIMIT);
	assign status.div_more  = (div_cnt_q != '0);
	assign status.out_block = res_valid_q && !result_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			gain_q    <= GAIN_W'(205);
			cpt_q     <= CPT_W'(1920);
			period_q  <= PER_W'(8);
			ceiling_q <= DUTY_W'(DUTY_MAX);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET:  target_q  <= cfg_data[SPEED_W-1:0];
				CFG_GAIN:    gain_q    <= cfg_data[GAIN_W-1:0];
				CFG_CPT:     cpt_q     <= cfg_data[CPT_W-1:0];
				CFG_PERIOD:  period_q  <= cfg_data[PER_W-1:0];
				CFG_CEILING: ceiling_q <= cfg_data[DUTY_W-1:0];
				default:     ;
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (accept)
			item_q <= item;
	end

	// Controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q   <= 1'b0;
			dir_bit_q  <= 1'b1;
			count_q    <= '0;
			prev_q     <= '0;
			speed_q    <= '0;
			duty_reg_q <= '0;
			dir_q      <= DIR_STOP;
		end else begin
			case (op)
				OP_SAMPLE: begin
					last_a_q  <= item_q.chan_a_level;
					dir_bit_q <= dir_new;
					if (!dir_new)
						count_q <= (count_q == COUNT_W'(COUNT_MODULUS - 1)) ? '0
						           : count_q + 1'b1;
					else
						count_q <= (count_q == '0) ? COUNT_W'(COUNT_MODULUS - 1)
						           : count_q - 1'b1;
				end
				OP_DIFF:  prev_q  <= count_q;
				OP_SPEED: speed_q <= speed_sat;
				OP_DUTY: begin
					duty_reg_q <= duty_new;
					if (target_q > 0)
						dir_q <= DIR_FWD;
					else if (target_q < 0)
						dir_q <= DIR_REV;
					else
						dir_q <= DIR_STOP;
				end
				default: ;
			endcase
		end
	end

	// Working registers of the tick program
	always_ff @(posedge clk) begin
		case (op)
			OP_SAMPLE: begin
				duty_out_q <= '0;
				written_q  <= 1'b0;
			end
			OP_DIFF: begin
				diff_q <= $signed({1'b0, count_q}) - $signed({1'b0, prev_q});
				den_q  <= DEN_W'(cpt_eff) * DEN_W'(per_eff);
			end
			OP_MUL1: acc_q <= ACC_W'(PROD1_W'(diff_mag[MAG_W-1:0]) * PROD1_W'(MS_SCALE));
			OP_MUL2: acc_q <= ACC_W'(acc_q[PROD1_W-1:0]) * ACC_W'(TWOPI_Q20);
			OP_DIV_INIT: begin
				num_q     <= acc_q[ACC_W-1:NUM_SHIFT];
				rem_q     <= '0;
				div_cnt_q <= DIV_CNT_W'(NUM_W - 1);
			end
			OP_DIV_STEP: begin
				rem_q     <= trial_ok ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
				num_q     <= {num_q[NUM_W-2:0], trial_ok};
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			OP_ERR: begin
				err_neg_q <= e_diff[SPEED_W+1];
				err_mag_q <= ERR_W'(e_abs) * ERR_W'(ERR_SCALE);
			end
			OP_PMUL: prod_q <= PROD_W'(err_mag_q) * PROD_W'(gain_q);
			OP_DUTY: begin
				written_q  <= (target_q != '0);
				duty_out_q <= (target_q == '0) ? '0
				              : ((duty_new > ceiling_q) ? ceiling_q : duty_new);
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (load_out)
			res_valid_q <= 1'b1;
		else if (result_ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q.position_count <= count_q;
			res_q.speed_q8       <= speed_q;
			res_q.duty           <= duty_out_q;
			res_q.duty_written   <= written_q;
			res_q.drive_dir      <= dir_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
`default_nettype wire

// ===== sv/encoder_velocity_duty_loop_unit.sv =====
// Encoder speed loop with proportional duty control.
// Request channel (item_valid/item_ready/item): opcode 0 is an encoder
// sample that tracks channel A/B and steps the wrapped position count;
// opcode 1 is a control tick that measures speed and updates the duty.
// Each request gives exactly one result on result_valid/result_ready/result.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// write it only while no request is in flight.
// A short microprogram sequences a shared datapath one step per cycle
// unless the output step is stalled. A sample runs dispatch, sample, output;
// a tick runs dispatch, difference, two multiplies, divider setup, the
// one-bit-per-cycle speed divider, speed, error, gain, duty and output.
// A tick whose count change is 10000 or more skips the divider. One request
// is in flight at a time; item_ready returns when the result is loaded.
// The result sits in an output register; a stalled receiver only holds the
// sequencer when a second result is ready to load into a full register.
// Reset clears the state, loads the register defaults (gain 205, 1920
// counts per turn, 8 ms period, ceiling 255) and empties the output.
`default_nettype none
module encoder_velocity_duty_loop_unit
	import evdl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire item_t                 item,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output result_t                    result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic        busy;
	logic        accept;
	op_t         op;
	seq_status_t status;

	assign item_ready = !busy;
	assign accept     = item_valid && item_ready;
	assign cfg_ready  = 1'b1;

	// Microprogram sequencer
	evdl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.status (status),
		.op     (op),
		.busy   (busy)
	);

	// Shared datapath
	evdl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (item),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.status       (status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

// ===== sv/evdl_checker.sv =====
`default_nettype none
module evdl_checker
	import evdl_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  item_valid,
	input wire logic                  item_ready,
	input wire item_t                 item,
	input wire logic                  result_valid,
	input wire logic                  result_ready,
	input wire result_t               result,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	// A held result stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// One request in flight
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("request taken while busy");

	// Position stays inside the wrap range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.position_count < COUNT_W'(COUNT_MODULUS))
		else $error("position out of range");

	// No duty unless written
	a_duty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.duty_written |-> result.duty == '0)
		else $error("duty without write");

	// A written duty always has a drive direction
	a_written_dir: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.duty_written |-> result.drive_dir != DIR_STOP)
		else $error("duty written while stopped");

endmodule

bind encoder_velocity_duty_loop_unit evdl_checker u_evdl_checker (.*);
`default_nettype wire
